>>> rtl/srwu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwu_pkg
// Shared codes, field masks and item types of the special register write unit.
// ----------------------------------------------------------------------------
package srwu_pkg;

	localparam int unsigned DataW    = 32;
	localparam int unsigned SysmW    = 8;
	localparam int unsigned MaskW    = 4;
	localparam int unsigned FlagsW   = 5;
	localparam int unsigned GeW      = 4;
	localparam int unsigned PriW     = 8;
	localparam int unsigned StatusW  = 2;

	// value field positions
	localparam int unsigned FlagsLsb = 27;
	localparam int unsigned GeLsb    = 16;

	// mask bits
	localparam int unsigned MaskFlagsBit = 3;
	localparam int unsigned MaskGeBit    = 2;

	// control register bits
	localparam int unsigned CtrlSpselBit = 1;
	localparam int unsigned CtrlNprivBit = 0;

	// dsp extension present after reset
	localparam logic DspEnabledReset = 1'b1;

	// special register numbers
	localparam logic [SysmW-1:0] SYSM_APSR_LAST    = 8'd3;
	localparam logic [SysmW-1:0] SYSM_PSR_LAST     = 8'd7;
	localparam logic [SysmW-1:0] SYSM_MSP          = 8'd8;
	localparam logic [SysmW-1:0] SYSM_PSP          = 8'd9;
	localparam logic [SysmW-1:0] SYSM_PRIMASK      = 8'd16;
	localparam logic [SysmW-1:0] SYSM_BASEPRI      = 8'd17;
	localparam logic [SysmW-1:0] SYSM_BASEPRI_COND = 8'd18;
	localparam logic [SysmW-1:0] SYSM_FAULTMASK    = 8'd19;
	localparam logic [SysmW-1:0] SYSM_CONTROL      = 8'd20;

	typedef enum logic [StatusW-1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_IGNORED = 2'd1,
		STATUS_UNKNOWN = 2'd2
	} status_t;

	typedef struct packed {
		logic [SysmW-1:0] sysm;
		logic [MaskW-1:0] write_mask;
		logic [DataW-1:0] write_value;
		logic             privileged;
	} cmd_item_t;

	typedef struct packed {
		logic [DataW-1:0]  active_sp;
		logic [DataW-1:0]  banked_sp;
		logic [FlagsW-1:0] flag_bits;
		logic [GeW-1:0]    ge_flags;
		logic              primask;
		logic              faultmask;
		logic [PriW-1:0]   basepri;
		logic              spsel;
		logic              npriv;
	} core_state_t;

	typedef struct packed {
		status_t     status;
		core_state_t state;
	} result_item_t;

endpackage

>>> rtl/srwu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwu_cmd_if / srwu_result_if
// Valid-ready channels for write commands and their results.
// ----------------------------------------------------------------------------
interface srwu_cmd_if
	import srwu_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [SysmW-1:0] sysm;
	logic [MaskW-1:0] write_mask;
	logic [DataW-1:0] write_value;
	logic             privileged;

	modport source (output valid, output sysm, output write_mask, output write_value,
		output privileged, input ready);
	modport sink (input valid, input sysm, input write_mask, input write_value,
		input privileged, output ready);
endinterface

interface srwu_result_if
	import srwu_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [StatusW-1:0] status;
	logic [DataW-1:0]   current_sp;
	logic [DataW-1:0]   other_stack;
	logic [FlagsW-1:0]  nzcvq;
	logic [GeW-1:0]     ge_bits;
	logic               irq_masked;
	logic               fault_masked;
	logic [PriW-1:0]    base_priority;
	logic               stack_select;
	logic               unpriv_thread;

	modport source (output valid, output status, output current_sp, output other_stack,
		output nzcvq, output ge_bits, output irq_masked, output fault_masked,
		output base_priority, output stack_select, output unpriv_thread, input ready);
	modport sink (input valid, input status, input current_sp, input other_stack,
		input nzcvq, input ge_bits, input irq_masked, input fault_masked,
		input base_priority, input stack_select, input unpriv_thread, output ready);
endinterface

>>> rtl/special_register_write_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// special_register_write_unit
// Executes move-to-special-register writes and reports the resulting state.
// ----------------------------------------------------------------------------
// cmd: valid-ready channel with sysm, write_mask, write_value and privileged.
// result: valid-ready channel with the status and the full register state
// after the write, one result per command, in command order.
// cfg_we / cfg_wdata: writes dsp_enabled (GE bits writable when 1); write
// only while no command is in flight.
// A cmd transfer passes through the command register and then the result
// register before its result can transfer. Throughput is one command per
// cycle while the receiver does not stall, set by the combinational decode
// and state update between the two registers.
// Reset clears all stack pointers, flags and masks, sets dsp_enabled and
// empties both registers.
// When the receiver stalls, the result register holds; one more command
// waits in the command register, then cmd.ready drops until the result is
// taken.
// ----------------------------------------------------------------------------
module special_register_write_unit
	import srwu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srwu_cmd_if.sink   cmd,
	srwu_result_if.source result,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic         cmd_valid_s1;
	cmd_item_t    cmd_s1;
	logic         res_valid_q;
	result_item_t res_q;
	core_state_t  state_q;
	core_state_t  state_next;
	status_t      status_next;
	logic         dsp_enabled_q;
	logic         advance;
	logic [PriW-1:0] v8;

	assign advance   = !res_valid_q || result.ready;
	assign cmd.ready = !cmd_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsp_enabled_q <= DspEnabledReset;
		end else if (cfg_we) begin
			dsp_enabled_q <= cfg_wdata;
		end
	end

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.sysm        <= cmd.sysm;
			cmd_s1.write_mask  <= cmd.write_mask;
			cmd_s1.write_value <= cmd.write_value;
			cmd_s1.privileged  <= cmd.privileged;
		end
	end

	// decode and update
	assign v8 = cmd_s1.write_value[PriW-1:0];

	always_comb begin
		state_next  = state_q;
		status_next = STATUS_DONE;
		if (!cmd_s1.privileged && cmd_s1.sysm > SYSM_PSR_LAST) begin
			status_next = STATUS_IGNORED;
		end else if (cmd_s1.sysm inside {[8'd0:SYSM_PSR_LAST]}) begin
			if (cmd_s1.sysm inside {[8'd0:SYSM_APSR_LAST]}) begin
				if (cmd_s1.write_mask[MaskFlagsBit]) begin
					state_next.flag_bits = cmd_s1.write_value[FlagsLsb +: FlagsW];
				end
				if (cmd_s1.write_mask[MaskGeBit] && dsp_enabled_q) begin
					state_next.ge_flags = cmd_s1.write_value[GeLsb +: GeW];
				end
			end
		end else begin
			case (cmd_s1.sysm)
				SYSM_MSP: begin
					if (state_q.spsel) state_next.banked_sp = cmd_s1.write_value;
					else state_next.active_sp = cmd_s1.write_value;
				end
				SYSM_PSP: begin
					if (state_q.spsel) state_next.active_sp = cmd_s1.write_value;
					else state_next.banked_sp = cmd_s1.write_value;
				end
				SYSM_PRIMASK: state_next.primask = cmd_s1.write_value[0];
				SYSM_BASEPRI: state_next.basepri = v8;
				SYSM_BASEPRI_COND: begin
					if (v8 != '0 && (v8 < state_q.basepri || state_q.basepri == '0)) begin
						state_next.basepri = v8;
					end
				end
				SYSM_FAULTMASK: state_next.faultmask = cmd_s1.write_value[0];
				SYSM_CONTROL: begin
					if (cmd_s1.write_value[CtrlSpselBit] != state_q.spsel) begin
						state_next.active_sp = state_q.banked_sp;
						state_next.banked_sp = state_q.active_sp;
					end
					state_next.spsel = cmd_s1.write_value[CtrlSpselBit];
					state_next.npriv = cmd_s1.write_value[CtrlNprivBit];
				end
				default: status_next = STATUS_UNKNOWN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= cmd_valid_s1;
			if (cmd_valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && cmd_valid_s1) begin
			res_q.status <= status_next;
			res_q.state  <= state_next;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = res_q.status;
	assign result.current_sp    = res_q.state.active_sp;
	assign result.other_stack   = res_q.state.banked_sp;
	assign result.nzcvq         = res_q.state.flag_bits;
	assign result.ge_bits       = res_q.state.ge_flags;
	assign result.irq_masked    = res_q.state.primask;
	assign result.fault_masked  = res_q.state.faultmask;
	assign result.base_priority = res_q.state.basepri;
	assign result.stack_select  = res_q.state.spsel;
	assign result.unpriv_thread = res_q.state.npriv;

endmodule

>>> rtl/srwu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwu_checker
// Port-level checks of the special register write unit, bound to the top.
// ----------------------------------------------------------------------------
module srwu_checker
	import srwu_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [StatusW-1:0] res_status,
	input logic [DataW-1:0]   res_current_sp,
	input logic [DataW-1:0]   res_other_stack,
	input logic [PriW-1:0]    res_base_priority
);

	// only a stalled result can hold off a command
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> (res_valid && !res_ready))
		else $error("cmd ready low without a stalled result");

	// status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == STATUS_DONE || res_status == STATUS_IGNORED
			|| res_status == STATUS_UNKNOWN))
		else $error("undefined status code");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result valid dropped before transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> ($stable(res_status) && $stable(res_current_sp)
			&& $stable(res_other_stack) && $stable(res_base_priority)))
		else $error("stalled result changed");

endmodule

bind special_register_write_unit srwu_checker u_srwu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_ready        (cmd.ready),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.res_status       (result.status),
	.res_current_sp   (result.current_sp),
	.res_other_stack  (result.other_stack),
	.res_base_priority(result.base_priority)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the special register write unit. A directed run covers
// every register number, the mask bits, the stack swap on CONTROL, the
// conditional BASEPRI lowering rules, unprivileged and unknown writes; a random
// run follows under both DSP settings. A scoreboard keeps its own copy of the
// core state, predicts each result and compares it field by field, while
// both channel sides idle at random and the receiver holds off at length.
// ----------------------------------------------------------------------------
module tb_top;
	import srwu_pkg::*;

	class msr_scoreboard;
		core_state_t  regs;
		bit           dsp_on;
		result_item_t expected_results[$];
		int unsigned  errors;

		function new();
			regs    = '0;
			dsp_on  = DspEnabledReset;
			errors  = 0;
		endfunction

		function void set_dsp(bit v);
			dsp_on = v;
		endfunction

		function int unsigned pending_count();
			return expected_results.size();
		endfunction

		// apply one accepted write to the state copy and queue its result
		function void note_command(cmd_item_t c);
			result_item_t     r;
			logic [PriW-1:0]  pri;
			logic [DataW-1:0] t;
			pri      = c.write_value[PriW-1:0];
			r.status = STATUS_DONE;
			if (!c.privileged && c.sysm > SYSM_PSR_LAST) begin
				r.status = STATUS_IGNORED;
			end else if (c.sysm <= SYSM_PSR_LAST) begin
				if (c.sysm <= SYSM_APSR_LAST) begin
					if (c.write_mask[MaskFlagsBit])
						regs.flag_bits = c.write_value[FlagsLsb +: FlagsW];
					if (c.write_mask[MaskGeBit] && dsp_on)
						regs.ge_flags = c.write_value[GeLsb +: GeW];
				end
			end else begin
				case (c.sysm)
					SYSM_MSP: begin
						if (regs.spsel) regs.banked_sp = c.write_value;
						else regs.active_sp = c.write_value;
					end
					SYSM_PSP: begin
						if (regs.spsel) regs.active_sp = c.write_value;
						else regs.banked_sp = c.write_value;
					end
					SYSM_PRIMASK: regs.primask = c.write_value[0];
					SYSM_BASEPRI: regs.basepri = pri;
					SYSM_BASEPRI_COND: begin
						if (pri != 0 && (pri < regs.basepri || regs.basepri == 0))
							regs.basepri = pri;
					end
					SYSM_FAULTMASK: regs.faultmask = c.write_value[0];
					SYSM_CONTROL: begin
						if (c.write_value[CtrlSpselBit] != regs.spsel) begin
							t              = regs.active_sp;
							regs.active_sp = regs.banked_sp;
							regs.banked_sp = t;
						end
						regs.spsel = c.write_value[CtrlSpselBit];
						regs.npriv = c.write_value[CtrlNprivBit];
					end
					default: r.status = STATUS_UNKNOWN;
				endcase
			end
			r.state = regs;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [DataW-1:0] want,
				logic [DataW-1:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("%0t: %s mismatch, expected %h, got %h", $realtime, name,
						want, got);
			end
		endfunction

		function void check_result(result_item_t got);
			result_item_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with no command outstanding", $realtime);
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", DataW'(want.status), DataW'(got.status));
			compare_field("current_sp", want.state.active_sp, got.state.active_sp);
			compare_field("other_stack", want.state.banked_sp, got.state.banked_sp);
			compare_field("nzcvq", DataW'(want.state.flag_bits),
				DataW'(got.state.flag_bits));
			compare_field("ge_bits", DataW'(want.state.ge_flags),
				DataW'(got.state.ge_flags));
			compare_field("irq_masked", DataW'(want.state.primask),
				DataW'(got.state.primask));
			compare_field("fault_masked", DataW'(want.state.faultmask),
				DataW'(got.state.faultmask));
			compare_field("base_priority", DataW'(want.state.basepri),
				DataW'(got.state.basepri));
			compare_field("stack_select", DataW'(want.state.spsel),
				DataW'(got.state.spsel));
			compare_field("unpriv_thread", DataW'(want.state.npriv),
				DataW'(got.state.npriv));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	srwu_cmd_if    cmd_ch ();
	srwu_result_if res_ch ();

	msr_scoreboard sb;

	bit          src_gaps;
	bit          sink_stalls;
	int unsigned hold_request;

	special_register_write_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	initial begin : watchdog
		#5000000;
		$display("special_register_write_unit regression: fail");
		$finish;
	end

	// entered and left at a falling edge
	task automatic issue(cmd_item_t c);
		int unsigned gap;
		gap = src_gaps ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.sysm        <= c.sysm;
		cmd_ch.write_mask  <= c.write_mask;
		cmd_ch.write_value <= c.write_value;
		cmd_ch.privileged  <= c.privileged;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic issue_fields(logic [SysmW-1:0] s, logic [MaskW-1:0] m,
			logic [DataW-1:0] v, logic p);
		cmd_item_t c;
		c.sysm        = s;
		c.write_mask  = m;
		c.write_value = v;
		c.privileged  = p;
		issue(c);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (sb.pending_count() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_dsp(bit v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_dsp(v);
	endtask

	function automatic cmd_item_t random_command();
		cmd_item_t   c;
		int unsigned pick;
		pick          = $urandom_range(0, 99);
		c.write_mask  = MaskW'($urandom_range(0, 15));
		c.write_value = $urandom;
		c.privileged  = ($urandom_range(0, 9) != 0);
		if (pick < 30) c.sysm = SysmW'($urandom_range(0, 7));
		else if (pick < 45) c.sysm = SysmW'($urandom_range(8, 9));
		else if (pick < 80) c.sysm = SysmW'($urandom_range(16, 20));
		else if (pick < 88) c.sysm = SysmW'($urandom_range(10, 15));
		else c.sysm = SysmW'($urandom_range(0, 255));
		// few distinct priorities so equal and lower values show up often
		if ((c.sysm == SYSM_BASEPRI || c.sysm == SYSM_BASEPRI_COND) && $urandom_range(0, 1))
			c.write_value[PriW-1:0] = PriW'($urandom_range(0, 3) << 6);
		return c;
	endfunction

	task automatic run_random(int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 50 == 0) begin
				src_gaps    = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			issue(random_command());
		end
	endtask

	initial begin : result_sink
		int unsigned stall;
		res_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end else begin
				stall = sink_stalls ? $urandom_range(0, 14) : 0;
				if (stall > 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		result_item_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.status          = status_t'(res_ch.status);
			got.state.active_sp = res_ch.current_sp;
			got.state.banked_sp = res_ch.other_stack;
			got.state.flag_bits = res_ch.nzcvq;
			got.state.ge_flags  = res_ch.ge_bits;
			got.state.primask   = res_ch.irq_masked;
			got.state.faultmask = res_ch.fault_masked;
			got.state.basepri   = res_ch.base_priority;
			got.state.spsel     = res_ch.stack_select;
			got.state.npriv     = res_ch.unpriv_thread;
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		sb                 = new();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.sysm        = '0;
		cmd_ch.write_mask  = '0;
		cmd_ch.write_value = '0;
		cmd_ch.privileged  = 1'b0;
		src_gaps           = 1'b1;
		sink_stalls        = 1'b1;
		hold_request       = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// flags and ge bits, unused mask bits, psr numbers with no effect
		issue_fields(8'd0, 4'h8, 32'hffff_ffff, 1'b1);
		issue_fields(8'd0, 4'h4, 32'h000f_0000, 1'b1);
		issue_fields(8'd3, 4'hf, 32'h0000_0000, 1'b1);
		issue_fields(8'd2, 4'hc, 32'ha80a_0000, 1'b1);
		issue_fields(8'd1, 4'h3, 32'hffff_ffff, 1'b1);
		issue_fields(8'd5, 4'hf, 32'hffff_ffff, 1'b1);
		issue_fields(SYSM_PSR_LAST, 4'hf, 32'h0000_0000, 1'b1);
		issue_fields(8'd2, 4'h8, 32'h5000_0000, 1'b0);
		// stack pointers around a stack select change
		issue_fields(SYSM_MSP, 4'h0, 32'h2000_1000, 1'b1);
		issue_fields(SYSM_PSP, 4'hf, 32'h2000_2000, 1'b1);
		issue_fields(SYSM_CONTROL, 4'h0, 32'h0000_0002, 1'b1);
		issue_fields(SYSM_MSP, 4'h0, 32'hffff_ffff, 1'b1);
		issue_fields(SYSM_PSP, 4'h0, 32'h0000_0000, 1'b1);
		issue_fields(SYSM_CONTROL, 4'h0, 32'hffff_fffd, 1'b1);
		// masks and priority lowering
		issue_fields(SYSM_PRIMASK, 4'h0, 32'h0000_0001, 1'b1);
		issue_fields(SYSM_BASEPRI, 4'h0, 32'hffff_ff80, 1'b1);
		issue_fields(SYSM_BASEPRI_COND, 4'h0, 32'h0000_0040, 1'b1);
		issue_fields(SYSM_BASEPRI_COND, 4'h0, 32'h0000_00c0, 1'b1);
		issue_fields(SYSM_BASEPRI_COND, 4'h0, 32'hffff_ff00, 1'b1);
		issue_fields(SYSM_BASEPRI, 4'h0, 32'h0000_0000, 1'b1);
		issue_fields(SYSM_BASEPRI_COND, 4'h0, 32'h0000_00ff, 1'b1);
		issue_fields(SYSM_FAULTMASK, 4'h0, 32'hffff_ffff, 1'b1);
		// unprivileged and unknown numbers
		issue_fields(SYSM_MSP, 4'hf, 32'h1234_5678, 1'b0);
		issue_fields(8'd10, 4'h0, 32'hffff_ffff, 1'b1);
		issue_fields(8'd255, 4'hf, 32'hffff_ffff, 1'b1);
		wait_drained();

		set_dsp(1'b0);
		run_random(250);
		wait_drained();

		set_dsp(1'b1);
		// long receiver hold while transfers keep coming
		src_gaps     = 1'b0;
		hold_request = 60;
		for (int i = 0; i < 30; i++) issue(random_command());
		wait_drained();
		run_random(220);
		wait_drained();

		set_dsp(1'b0);
		run_random(200);
		wait_drained();

		set_dsp(1'b1);
		run_random(200);
		wait_drained();
		repeat (10) @(negedge clk);

		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("special_register_write_unit regression: pass");
		end else begin
			$display("special_register_write_unit regression: fail");
		end
		$finish;
	end
endmodule
